// ===== hdl/anagram_window_matcher_macros.svh =====
// ----------------------------------------------------------------------------
// anagram window matcher assertion macros
// shared concurrent assertion forms, clocked on clk_i, off while rst_ni low
// ----------------------------------------------------------------------------
`ifndef ANAGRAM_WINDOW_MATCHER_MACROS_SVH
`define ANAGRAM_WINDOW_MATCHER_MACROS_SVH

// consequent checked in the same cycle
`define AWM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("awm assertion failed");

// consequent checked in the cycle after the antecedent
`define AWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("awm assertion failed");

`endif

// ===== hdl/awm_pkg.sv =====
// ----------------------------------------------------------------------------
// awm_pkg
// shared types and constants of the anagram window matcher
// ----------------------------------------------------------------------------
package awm_pkg;

  localparam int unsigned AWM_MAX_PATTERN = 64;
  localparam int unsigned AWM_ALPHABET    = 26;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned SYM_W           = 5;

  typedef enum logic [OP_W-1:0] {
    OP_FIRST = 2'd0,
    OP_MORE  = 2'd1,
    OP_TEXT  = 2'd2,
    OP_IDLE  = 2'd3
  } awm_op_e;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [SYM_W-1:0] symbol;
  } awm_in_t;

  typedef struct packed {
    logic match;
    logic found;
    logic rejected;
  } awm_out_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic inc;
    logic dec;
  } awm_cell_ctl_t;

endpackage

// ===== hdl/awm_letter_cell.sv =====
// ----------------------------------------------------------------------------
// awm_letter_cell
// difference counter for one letter class: pattern count minus window count
// ----------------------------------------------------------------------------
module awm_letter_cell #(
  parameter int unsigned DIFF_W = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  awm_pkg::awm_cell_ctl_t ctl_i,
  output logic                  nz_o
);

  logic [DIFF_W-1:0] diff_q;
  logic [DIFF_W-1:0] diff_d;
  logic [DIFF_W-1:0] base;

  always_comb begin
    base   = ctl_i.clr ? '0 : diff_q;
    diff_d = base + DIFF_W'(ctl_i.inc) - DIFF_W'(ctl_i.dec);
  end

  // nonzero flag of the value after this beat
  assign nz_o = |diff_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q <= '0;
    end else if (ctl_i.en) begin
      diff_q <= diff_d;
    end
  end

endmodule

// ===== hdl/anagram_window_matcher.sv =====
// ----------------------------------------------------------------------------
// anagram_window_matcher
// sliding window anagram search over a letter stream
// ----------------------------------------------------------------------------
// Pattern symbols (operation 0 starts a new pattern, 1 extends it) are loaded
// first, then text symbols are streamed; every beat in gives exactly one beat
// out with match, sticky found and rejected. One beat is taken per clock when
// the output does not stall. A result is registered in the input register,
// then in the result register; a stalled result holds the input register,
// which then stalls the input. Each letter class has its own difference
// counter, so a text beat touches at most two counters in one cycle; the last
// pattern length text classes sit in a ring memory with one write and one
// registered read per cycle, the read prefetched at the next head position,
// so that the leaving class is ready when the next text beat arrives.
module anagram_window_matcher #(
  parameter int unsigned MAX_PATTERN = awm_pkg::AWM_MAX_PATTERN,
  parameter int unsigned ALPHABET    = awm_pkg::AWM_ALPHABET
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  awm_pkg::awm_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output awm_pkg::awm_out_t out_data_o
);

  localparam int unsigned NCLS   = ALPHABET + 1;
  localparam int unsigned CLS_W  = $clog2(ALPHABET + 1);
  localparam int unsigned PLEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned HEAD_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned DIFF_W = $clog2(MAX_PATTERN + 1) + 1;

  // input and result stages
  logic              in_valid_q;
  awm_pkg::awm_in_t  in_q;
  logic              out_valid_q;
  awm_pkg::awm_out_t out_q;
  logic              fire;

  // window state
  logic [PLEN_W-1:0] plen_q, plen_d;
  logic [PLEN_W-1:0] filled_q, filled_d;
  logic [HEAD_W-1:0] head_q, head_d;
  logic              text_started_q, text_started_d;
  logic              found_q, found_d;

  // ring memory
  logic [CLS_W-1:0]  ring_mem [MAX_PATTERN];
  logic [CLS_W-1:0]  oldest_q;
  logic              ring_we;

  awm_pkg::awm_cell_ctl_t cell_ctl [NCLS];
  logic [NCLS-1:0]        cell_nz;

  awm_pkg::awm_op_e  op;
  logic [CLS_W-1:0]  cls;
  logic              sym_ok;
  logic              pat_op;
  logic              pat_add;
  logic              text_op;
  logic              text_live;
  logic              full;
  logic              match;
  logic [PLEN_W-1:0] head_inc;
  awm_pkg::awm_out_t res;

  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_comb begin
    op     = awm_pkg::awm_op_e'(in_q.operation);
    sym_ok = 32'(in_q.symbol) < ALPHABET;
    cls    = sym_ok ? CLS_W'(in_q.symbol) : CLS_W'(ALPHABET);

    pat_op  = 1'b0;
    text_op = 1'b0;
    unique case (op)
      awm_pkg::OP_FIRST: pat_op  = 1'b1;
      awm_pkg::OP_MORE:  pat_op  = 1'b1;
      awm_pkg::OP_TEXT:  text_op = 1'b1;
      awm_pkg::OP_IDLE:  pat_op  = 1'b0;
      default:           pat_op  = 1'b0;
    endcase

    // first pattern symbol sees a cleared block
    if (op == awm_pkg::OP_FIRST) begin
      pat_add = sym_ok;
    end else begin
      pat_add = pat_op && sym_ok && !text_started_q && (32'(plen_q) < MAX_PATTERN);
    end

    text_live = text_op && (plen_q != '0);
    full      = filled_q >= plen_q;
    head_inc  = PLEN_W'(head_q) + PLEN_W'(1);
  end

  always_comb begin
    for (int i = 0; i < NCLS; i++) begin
      cell_ctl[i].en  = fire;
      cell_ctl[i].clr = fire && (op == awm_pkg::OP_FIRST);
      cell_ctl[i].inc = fire && ((pat_add && (cls == CLS_W'(i))) ||
                                 (text_live && full && (oldest_q == CLS_W'(i))));
      cell_ctl[i].dec = fire && text_live && (cls == CLS_W'(i));
    end
  end

  for (genvar g = 0; g < NCLS; g++) begin : g_cell
    awm_letter_cell #(
      .DIFF_W(DIFF_W)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (cell_ctl[g]),
      .nz_o  (cell_nz[g])
    );
  end

  always_comb begin
    plen_d         = plen_q;
    filled_d       = filled_q;
    head_d         = head_q;
    text_started_d = text_started_q;
    found_d        = found_q;
    match          = 1'b0;
    ring_we        = 1'b0;

    if (fire) begin
      if (op == awm_pkg::OP_FIRST) begin
        plen_d         = pat_add ? PLEN_W'(1) : '0;
        filled_d       = '0;
        head_d         = '0;
        text_started_d = 1'b0;
        found_d        = 1'b0;
      end else if (pat_add) begin
        plen_d = plen_q + PLEN_W'(1);
      end else if (text_op) begin
        text_started_d = 1'b1;
        if (!text_live) begin
          match = 1'b1;
        end else begin
          ring_we  = 1'b1;
          filled_d = full ? filled_q : filled_q + PLEN_W'(1);
          head_d   = (head_inc >= plen_q) ? '0 : HEAD_W'(head_inc);
          match    = (filled_d == plen_q) && !(|cell_nz);
        end
        found_d = found_q || match;
      end
    end

    res.match    = match;
    res.found    = found_d;
    res.rejected = pat_op && !pat_add;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q         <= '0;
      filled_q       <= '0;
      head_q         <= '0;
      text_started_q <= 1'b0;
      found_q        <= 1'b0;
    end else begin
      plen_q         <= plen_d;
      filled_q       <= filled_d;
      head_q         <= head_d;
      text_started_q <= text_started_d;
      found_q        <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[head_q] <= cls;
    end
  end

  // prefetch the entry that leaves the window on the next text beat
  always_ff @(posedge clk_i) begin
    if (ring_we && (head_q == head_d)) begin
      oldest_q <= cls;
    end else begin
      oldest_q <= ring_mem[head_d];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`include "anagram_window_matcher_macros.svh"

  `AWM_ASSERT_SAME(a_filled_le_plen, 1'b1, filled_q <= plen_q)
  `AWM_ASSERT_SAME(a_head_in_window, text_started_q && (plen_q != '0), PLEN_W'(head_q) < plen_q)
  `AWM_ASSERT_SAME(a_match_sets_found, out_valid_q && out_q.match, out_q.found)
  `AWM_ASSERT_NEXT(a_text_marks_start, fire && text_op, text_started_q)

endmodule
